// File: design/alp_pkg.sv
// Shared types and codes for the array-backed linked list.
// No dependencies; used by array_linked_list_positional.
package alp_pkg;

   typedef logic [1:0] status_type;

   localparam status_type ST_OK     = 2'd0;
   localparam status_type ST_BADPOS = 2'd1;
   localparam status_type ST_NOFREE = 2'd2;

   localparam logic FUNC_INSERT = 1'b0;
   localparam logic FUNC_DELETE = 1'b1;

   localparam int POS_W = 5;
   localparam int LEN_W = 5;
   localparam int VAL_W = 8;

endpackage

// File: design/array_linked_list_positional.sv
// Linked list of bytes kept in a node array, with a free list; top level.
// Depends on alp_pkg and alp_ram (link memory and data memory).
//
//   channel | direction | handshake            | payload
//   --------+-----------+----------------------+--------------------------------
//   req     | in        | req_valid/req_stall  | req_func, req_position, req_value
//   rsp     | out       | rsp_valid/rsp_stall  | rsp_status, rsp_list_length
//
// After reset the link memory is rebuilt as the free chain, one node per cycle,
// with req_stall high.
// A request walks position-1 links, one link-memory read per cycle; a good insert first pops
// and unlinks a free node, and a good insert or delete then splices its links before the
// response state. A bad position goes straight to the response state, and an insert with
// no free node goes there from the pop. The single link-memory read port sets the walk rate.
// The response waits in an output register; a new request is taken while it waits.
module array_linked_list_positional #(
   parameter int NODE_COUNT = 32
) (
   input  logic                              clock,
   input  logic                              reset,
   input  logic                              req_valid,
   output logic                              req_stall,
   input  logic                              req_func,
   input  logic [alp_pkg::POS_W-1:0]         req_position,
   input  logic [alp_pkg::VAL_W-1:0]         req_value,
   output logic                              rsp_valid,
   input  logic                              rsp_stall,
   output alp_pkg::status_type               rsp_status,
   output logic [alp_pkg::LEN_W-1:0]         rsp_list_length
);

   localparam int AW   = $clog2(NODE_COUNT);
   localparam int CMPW = ((AW > alp_pkg::POS_W) ? AW : alp_pkg::POS_W) + 1;

   localparam logic [AW-1:0] FREE_HEAD = '0;
   localparam logic [AW-1:0] DATA_HEAD = AW'(NODE_COUNT - 1);
   localparam logic [AW-1:0] MAX_COUNT = AW'(NODE_COUNT - 2);

   localparam logic [3:0] S_CLEAR      = 4'd0;
   localparam logic [3:0] S_IDLE       = 4'd1;
   localparam logic [3:0] S_INS_POP    = 4'd2;
   localparam logic [3:0] S_INS_UNLINK = 4'd3;
   localparam logic [3:0] S_WALK       = 4'd4;
   localparam logic [3:0] S_INS_SPLICE = 4'd5;
   localparam logic [3:0] S_INS_HOOK   = 4'd6;
   localparam logic [3:0] S_DEL_TAKE   = 4'd7;
   localparam logic [3:0] S_DEL_BYPASS = 4'd8;
   localparam logic [3:0] S_DEL_FREE   = 4'd9;
   localparam logic [3:0] S_DEL_HEAD   = 4'd10;
   localparam logic [3:0] S_RESP       = 4'd11;

   // Control state.
   logic [3:0]                  state_ff, state_in;
   logic [AW-1:0]               clear_ff, clear_in;
   logic [AW-1:0]               count_ff, count_in;
   logic                        rsp_valid_ff, rsp_valid_in;
   logic                        pending_ff, pending_in;

   // Per-request working registers.
   logic                        func_ff, func_in;
   logic [alp_pkg::VAL_W-1:0]   value_ff, value_in;
   logic [alp_pkg::POS_W-1:0]   steps_ff, steps_in;
   logic [AW-1:0]               walk_node_ff, walk_node_in;
   logic [AW-1:0]               prev_ff, prev_in;
   logic [AW-1:0]               node_ff, node_in;
   alp_pkg::status_type         status_ff, status_in;
   alp_pkg::status_type         rsp_status_ff, rsp_status_in;
   logic [alp_pkg::LEN_W-1:0]   rsp_length_ff, rsp_length_in;

   // Memory ports.
   logic                        link_we;
   logic [AW-1:0]               link_wa;
   logic [AW-1:0]               link_wd;
   logic [AW-1:0]               link_ra;
   logic [AW-1:0]               link_rd;
   logic                        data_we;

   logic [CMPW-1:0]             pos_ext;
   logic [CMPW-1:0]             cnt_ext;
   logic [AW:0]                 clear_next;
   logic [AW-1:0]               cur_node;
   logic                        rsp_free;

   alp_ram #(.WIDTH(AW), .DEPTH(NODE_COUNT)) u_link_ram (
      .clock   (clock),
      .wr_en   (link_we),
      .wr_addr (link_wa),
      .wr_data (link_wd),
      .rd_addr (link_ra),
      .rd_data (link_rd)
   );

   // Node bytes are stored but never read back by any request.
   alp_ram #(.WIDTH(alp_pkg::VAL_W), .DEPTH(NODE_COUNT)) u_data_ram (
      .clock   (clock),
      .wr_en   (data_we),
      .wr_addr (node_ff),
      .wr_data (value_ff),
      .rd_addr (FREE_HEAD),
      .rd_data ()
   );

   assign pos_ext    = CMPW'(req_position);
   assign cnt_ext    = CMPW'(count_ff);
   assign clear_next = {1'b0, clear_ff} + (AW + 1)'(1);
   // While walking, the link just read is the node to step from.
   assign cur_node   = pending_ff ? link_rd : walk_node_ff;
   assign rsp_free   = !(rsp_valid_ff && rsp_stall);

   always_comb begin
      state_in      = state_ff;
      clear_in      = clear_ff;
      count_in      = count_ff;
      pending_in    = pending_ff;
      func_in       = func_ff;
      value_in      = value_ff;
      steps_in      = steps_ff;
      walk_node_in  = walk_node_ff;
      prev_in       = prev_ff;
      node_in       = node_ff;
      status_in     = status_ff;
      rsp_status_in = rsp_status_ff;
      rsp_length_in = rsp_length_ff;
      rsp_valid_in  = rsp_valid_ff && rsp_stall;
      link_we       = 1'b0;
      link_wa       = '0;
      link_wd       = '0;
      link_ra       = FREE_HEAD;
      data_we       = 1'b0;

      unique case (state_ff)
         S_CLEAR: begin
            link_we  = 1'b1;
            link_wa  = clear_ff;
            link_wd  = (clear_next < (AW + 1)'(NODE_COUNT - 1)) ? clear_next[AW-1:0] : '0;
            clear_in = clear_next[AW-1:0];
            if (clear_ff == DATA_HEAD) begin
               state_in = S_IDLE;
            end
         end
         S_IDLE: begin
            if (req_valid) begin
               func_in      = req_func;
               value_in     = req_value;
               steps_in     = req_position - alp_pkg::POS_W'(1);
               walk_node_in = DATA_HEAD;
               pending_in   = 1'b0;
               if (req_func == alp_pkg::FUNC_INSERT) begin
                  if (req_position == '0 || pos_ext > cnt_ext + CMPW'(1)) begin
                     status_in = alp_pkg::ST_BADPOS;
                     state_in  = S_RESP;
                  end else begin
                     link_ra  = FREE_HEAD;
                     state_in = S_INS_POP;
                  end
               end else begin
                  if (req_position == '0 || pos_ext > cnt_ext) begin
                     status_in = alp_pkg::ST_BADPOS;
                     state_in  = S_RESP;
                  end else begin
                     state_in = S_WALK;
                  end
               end
            end
         end
         S_INS_POP: begin
            if (link_rd == FREE_HEAD) begin
               status_in = alp_pkg::ST_NOFREE;
               state_in  = S_RESP;
            end else begin
               node_in  = link_rd;
               link_ra  = link_rd;
               state_in = S_INS_UNLINK;
            end
         end
         S_INS_UNLINK: begin
            link_we  = 1'b1;
            link_wa  = FREE_HEAD;
            link_wd  = link_rd;
            data_we  = 1'b1;
            state_in = S_WALK;
         end
         S_WALK: begin
            link_ra = cur_node;
            if (steps_ff == '0) begin
               // The read issued now fetches the successor of the node before the spot.
               prev_in  = cur_node;
               state_in = (func_ff == alp_pkg::FUNC_INSERT) ? S_INS_SPLICE : S_DEL_TAKE;
            end else begin
               steps_in     = steps_ff - alp_pkg::POS_W'(1);
               walk_node_in = cur_node;
               pending_in   = 1'b1;
            end
         end
         S_INS_SPLICE: begin
            link_we  = 1'b1;
            link_wa  = node_ff;
            link_wd  = link_rd;
            state_in = S_INS_HOOK;
         end
         S_INS_HOOK: begin
            link_we   = 1'b1;
            link_wa   = prev_ff;
            link_wd   = node_ff;
            count_in  = count_ff + AW'(1);
            status_in = alp_pkg::ST_OK;
            state_in  = S_RESP;
         end
         S_DEL_TAKE: begin
            node_in  = link_rd;
            link_ra  = link_rd;
            state_in = S_DEL_BYPASS;
         end
         S_DEL_BYPASS: begin
            link_we  = 1'b1;
            link_wa  = prev_ff;
            link_wd  = link_rd;
            link_ra  = FREE_HEAD;
            state_in = S_DEL_FREE;
         end
         S_DEL_FREE: begin
            link_we  = 1'b1;
            link_wa  = node_ff;
            link_wd  = link_rd;
            state_in = S_DEL_HEAD;
         end
         S_DEL_HEAD: begin
            link_we   = 1'b1;
            link_wa   = FREE_HEAD;
            link_wd   = node_ff;
            count_in  = count_ff - AW'(1);
            status_in = alp_pkg::ST_OK;
            state_in  = S_RESP;
         end
         S_RESP: begin
            if (rsp_free) begin
               rsp_valid_in  = 1'b1;
               rsp_status_in = status_ff;
               rsp_length_in = alp_pkg::LEN_W'(count_ff);
               state_in      = S_IDLE;
            end
         end
         default: begin
            state_in = S_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= S_CLEAR;
         clear_ff     <= '0;
         count_ff     <= '0;
         rsp_valid_ff <= 1'b0;
         pending_ff   <= 1'b0;
      end else begin
         state_ff     <= state_in;
         clear_ff     <= clear_in;
         count_ff     <= count_in;
         rsp_valid_ff <= rsp_valid_in;
         pending_ff   <= pending_in;
      end
   end

   always_ff @(posedge clock) begin
      func_ff       <= func_in;
      value_ff      <= value_in;
      steps_ff      <= steps_in;
      walk_node_ff  <= walk_node_in;
      prev_ff       <= prev_in;
      node_ff       <= node_in;
      status_ff     <= status_in;
      rsp_status_ff <= rsp_status_in;
      rsp_length_ff <= rsp_length_in;
   end

   assign req_stall       = (state_ff != S_IDLE);
   assign rsp_valid       = rsp_valid_ff;
   assign rsp_status      = rsp_status_ff;
   assign rsp_list_length = rsp_length_ff;

   // The list never holds more than the nodes outside the two heads.
   assert property (@(posedge clock) disable iff (reset)
      count_ff <= MAX_COUNT)
      else $error("element count exceeds node capacity");

   // The free list runs dry exactly when the list is full.
   assert property (@(posedge clock) disable iff (reset)
      (state_ff == S_INS_POP) |-> ((link_rd == FREE_HEAD) == (count_ff == MAX_COUNT)))
      else $error("free list state disagrees with element count");

   // A node taken from the free list is never one of the heads.
   assert property (@(posedge clock) disable iff (reset)
      (state_ff == S_INS_UNLINK) |-> (node_ff != FREE_HEAD && node_ff != DATA_HEAD))
      else $error("allocated a head node");

   // The node unlinked by a delete is a real data node.
   assert property (@(posedge clock) disable iff (reset)
      (state_ff == S_DEL_TAKE) |-> (link_rd != FREE_HEAD && link_rd != DATA_HEAD))
      else $error("delete reached a head node");

   // A response is only loaded when the output register is free.
   assert property (@(posedge clock) disable iff (reset)
      (state_ff == S_RESP && rsp_valid_ff && rsp_stall) |=> (state_ff == S_RESP))
      else $error("response dropped while output stalled");

endmodule

// File: design/alp_ram.sv
// Generic single-write, single-read synchronous RAM with registered read data.
// No dependencies.
module alp_ram #(
   parameter int WIDTH = 8,
   parameter int DEPTH = 32
) (
   input  logic                     clock,
   input  logic                     wr_en,
   input  logic [$clog2(DEPTH)-1:0] wr_addr,
   input  logic [WIDTH-1:0]         wr_data,
   input  logic [$clog2(DEPTH)-1:0] rd_addr,
   output logic [WIDTH-1:0]         rd_data
);

   logic [WIDTH-1:0] mem [DEPTH];
   logic [WIDTH-1:0] rd_data_ff;

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem[wr_addr] <= wr_data;
      end
      rd_data_ff <= mem[rd_addr];
   end

   assign rd_data = rd_data_ff;

endmodule

// File: sim/list_checker.sv
// Scoreboard for the array-backed linked list: predicts status and length per request.
// Watches the req and rsp channels of array_linked_list_positional; depends on alp_pkg.
module list_checker #(
   parameter int NODE_COUNT = 32
) (
   input  logic                        clock,
   input  logic                        reset,
   input  logic                        req_valid,
   input  logic                        req_stall,
   input  logic                        req_func,
   input  logic [alp_pkg::POS_W-1:0]   req_position,
   input  logic                        rsp_valid,
   input  logic                        rsp_stall,
   input  alp_pkg::status_type         rsp_status,
   input  logic [alp_pkg::LEN_W-1:0]   rsp_list_length,
   output int                          outstanding,
   output int                          failures
);
   timeunit 1ns;
   timeprecision 1ps;

   localparam int LINK_W    = $clog2(NODE_COUNT);
   localparam int DATA_HEAD = NODE_COUNT - 1;

   typedef struct packed {
      alp_pkg::status_type            status;
      logic [alp_pkg::LEN_W-1:0]      length;
   } list_answer_type;

   logic [LINK_W-1:0] node_link [NODE_COUNT];
   int                list_count;
   list_answer_type   answer_q[$];

   function automatic void rebuild_free_chain();
      for (int i = 0; i < NODE_COUNT; i++) begin
         node_link[i] = (i + 1 < NODE_COUNT - 1) ? LINK_W'(i + 1) : '0;
      end
      list_count = 0;
   endfunction

   // Applies one request to the shadow list and returns its status.
   function automatic alp_pkg::status_type apply_request(input logic op, input int pos);
      int prev;
      int node;
      prev = DATA_HEAD;
      if (op == alp_pkg::FUNC_INSERT) begin
         if (pos < 1 || pos > list_count + 1) return alp_pkg::ST_BADPOS;
         if (node_link[0] == '0) return alp_pkg::ST_NOFREE;
         node = int'(node_link[0]);
         node_link[0] = node_link[node];
         for (int s = 1; s < pos; s++) prev = int'(node_link[prev]);
         node_link[node] = node_link[prev];
         node_link[prev] = LINK_W'(node);
         list_count++;
      end else begin
         if (pos < 1 || pos > list_count) return alp_pkg::ST_BADPOS;
         for (int s = 1; s < pos; s++) prev = int'(node_link[prev]);
         node = int'(node_link[prev]);
         node_link[prev] = node_link[node];
         // The freed node goes back to the head of the free list.
         node_link[node] = node_link[0];
         node_link[0] = LINK_W'(node);
         list_count--;
      end
      return alp_pkg::ST_OK;
   endfunction

   always @(posedge clock) begin : watch_channels
      list_answer_type     want;
      alp_pkg::status_type st;
      if (reset) begin
         rebuild_free_chain();
         answer_q.delete();
         outstanding <= 0;
      end else begin
         if (req_valid && !req_stall) begin
            st = apply_request(req_func, int'(req_position));
            answer_q.push_back('{status: st, length: alp_pkg::LEN_W'(list_count)});
         end
         if (rsp_valid && !rsp_stall) begin
            if (answer_q.size() == 0) begin
               $error("unexpected rsp beat: status %0d list_length %0d",
                      rsp_status, rsp_list_length);
               failures++;
            end else begin
               want = answer_q.pop_front();
               if (rsp_status !== want.status) begin
                  $error("rsp_status: expected %0d, got %0d", want.status, rsp_status);
                  failures++;
               end
               if (rsp_list_length !== want.length) begin
                  $error("rsp_list_length: expected %0d, got %0d",
                         want.length, rsp_list_length);
                  failures++;
               end
            end
         end
         outstanding <= answer_q.size();
      end
   end

endmodule

// File: sim/testbench.sv
// Top of the list regression: clock, reset, request stimulus and response back-pressure.
// Instantiates array_linked_list_positional and list_checker; depends on alp_pkg.
module testbench;
   timeunit 1ns;
   timeprecision 1ps;

   localparam int NODE_COUNT   = 32;
   localparam int MAX_LEN      = NODE_COUNT - 2;
   localparam int RANDOM_ITEMS = 2000;
   localparam int CYCLE_LIMIT  = 2_000_000;

   logic                         clock = 1'b0;
   logic                         reset = 1'b1;
   logic                         req_valid = 1'b0;
   logic                         req_stall;
   logic                         req_func = alp_pkg::FUNC_INSERT;
   logic [alp_pkg::POS_W-1:0]    req_position = '0;
   logic [alp_pkg::VAL_W-1:0]    req_value = '0;
   logic                         rsp_valid;
   logic                         rsp_stall = 1'b0;
   alp_pkg::status_type          rsp_status;
   logic [alp_pkg::LEN_W-1:0]    rsp_list_length;

   int outstanding;
   int failures;
   int cycle_count = 0;
   int shadow_len = 0;

   always begin
      #5 clock = 1'b1;
      #5 clock = 1'b0;
   end

   array_linked_list_positional #(.NODE_COUNT(NODE_COUNT)) dut (.*);

   list_checker #(.NODE_COUNT(NODE_COUNT)) u_list_checker (
      .clock, .reset, .req_valid, .req_stall, .req_func, .req_position,
      .rsp_valid, .rsp_stall, .rsp_status, .rsp_list_length,
      .outstanding, .failures
   );

   always @(posedge clock) begin
      cycle_count <= cycle_count + 1;
      if (cycle_count >= CYCLE_LIMIT) begin
         $display("Regression FAIL");
         $finish;
      end
   end

   // Mostly short gaps, now and then a long one.
   function automatic int gap_cycles();
      int r;
      r = $urandom_range(0, 99);
      if (r < 45) return 0;
      if (r < 85) return $urandom_range(1, 3);
      if (r < 97) return $urandom_range(4, 12);
      return $urandom_range(20, 80);
   endfunction

   initial begin : stall_rsp
      int quiet;
      int hold;
      forever begin
         quiet = ($urandom_range(0, 9) == 0) ? $urandom_range(50, 200) : $urandom_range(1, 12);
         rsp_stall <= 1'b0;
         repeat (quiet) @(posedge clock);
         hold = gap_cycles();
         if (hold > 0) begin
            rsp_stall <= 1'b1;
            repeat (hold) @(posedge clock);
         end
      end
   end

   // Drives one request beat, waits for it to be taken, then may idle a while.
   task automatic send_req(input logic op, input int pos, input int val);
      int gap;
      req_valid    <= 1'b1;
      req_func     <= op;
      req_position <= alp_pkg::POS_W'(pos);
      req_value    <= alp_pkg::VAL_W'(val);
      @(posedge clock);
      while (req_stall) @(posedge clock);
      if (op == alp_pkg::FUNC_INSERT) begin
         if (pos >= 1 && pos <= shadow_len + 1 && shadow_len < MAX_LEN) shadow_len++;
      end else if (pos >= 1 && pos <= shadow_len) begin
         shadow_len--;
      end
      gap = gap_cycles();
      if (gap > 0) begin
         req_valid <= 1'b0;
         repeat (gap) @(posedge clock);
      end
   endtask

   task automatic drain_responses();
      req_valid <= 1'b0;
      @(posedge clock);
      while (outstanding != 0) @(posedge clock);
   endtask

   initial begin : stimulus
      int   sent;
      int   phase;
      int   phase_len;
      int   insert_pct;
      int   pos;
      logic op;
      bit   full_seen;
      sent = 0;
      phase = 0;
      full_seen = 1'b0;

      repeat (6) @(posedge clock);
      reset <= 1'b0;

      // Directed: bounds on an empty and a short list, ends and middle.
      send_req(alp_pkg::FUNC_DELETE, 1, 'h00);
      send_req(alp_pkg::FUNC_INSERT, 0, 'h11);
      send_req(alp_pkg::FUNC_DELETE, 0, 'h22);
      send_req(alp_pkg::FUNC_INSERT, 2, 'h33);
      send_req(alp_pkg::FUNC_INSERT, 1, 'h00);
      send_req(alp_pkg::FUNC_INSERT, 1, 'hFF);
      send_req(alp_pkg::FUNC_INSERT, 3, 'hA5);
      send_req(alp_pkg::FUNC_INSERT, 2, 'h5A);
      send_req(alp_pkg::FUNC_INSERT, 6, 'h01);
      send_req(alp_pkg::FUNC_DELETE, 5, 'h02);
      send_req(alp_pkg::FUNC_DELETE, 4, 'h03);
      send_req(alp_pkg::FUNC_DELETE, 1, 'h04);
      send_req(alp_pkg::FUNC_DELETE, 2, 'h05);
      send_req(alp_pkg::FUNC_INSERT, 31, 'hFF);
      send_req(alp_pkg::FUNC_DELETE, 31, 'hFF);
      send_req(alp_pkg::FUNC_DELETE, 1, 'h06);

      // Random phases alternate between filling, draining and mixing.
      while (sent < RANDOM_ITEMS) begin
         drain_responses();
         case (phase % 3)
            0: insert_pct = 85;
            1: insert_pct = 15;
            default: insert_pct = 50;
         endcase
         phase_len = $urandom_range(120, 260);
         for (int i = 0; i < phase_len && sent < RANDOM_ITEMS; i++) begin
            if (shadow_len == MAX_LEN && !full_seen) begin
               // Full list: a good position finds no free node, a bad one is
               // still reported as a bad position.
               full_seen = 1'b1;
               send_req(alp_pkg::FUNC_INSERT, MAX_LEN + 1, $urandom_range(0, 255));
               send_req(alp_pkg::FUNC_INSERT, 0, $urandom_range(0, 255));
               send_req(alp_pkg::FUNC_INSERT, 15, $urandom_range(0, 255));
            end
            op = ($urandom_range(0, 99) < insert_pct) ? alp_pkg::FUNC_INSERT
                                                      : alp_pkg::FUNC_DELETE;
            if ($urandom_range(0, 9) == 0) begin
               op = 1'($urandom_range(0, 1));
               pos = $urandom_range(0, 31);
            end else if (op == alp_pkg::FUNC_INSERT) begin
               pos = $urandom_range(1, shadow_len + 1);
            end else if (shadow_len == 0) begin
               pos = $urandom_range(0, 31);
            end else begin
               pos = $urandom_range(1, shadow_len);
            end
            send_req(op, pos, $urandom_range(0, 255));
            sent++;
         end
         phase++;
      end

      req_valid <= 1'b0;
      @(posedge clock);
      while (outstanding != 0) @(posedge clock);
      repeat (64) @(posedge clock);
      if (failures == 0) begin
         $display("Regression PASS");
      end else begin
         $display("Regression FAIL");
      end
      $finish;
   end

endmodule

// File: sim.f
design/alp_pkg.sv
design/alp_ram.sv
design/array_linked_list_positional.sv
sim/list_checker.sv
sim/testbench.sv
